>>> hdl/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Types and constants shared by the local history branch predictor cells and
// the top level.
// ----------------------------------------------------------------------------
package lhbp_pkg;

  localparam int LHBP_TABLE_ENTRIES = 64;
  localparam int LHBP_HISTORY_BITS  = 2;

  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 2;
  localparam int IN_DATA_W  = 72;   // 65 payload bits padded to whole bytes
  localparam int OUT_DATA_W = 40;   // 35 payload bits padded to whole bytes

  localparam logic [CNT_W-1:0]  CNT_MAX         = 2'd3;
  localparam logic [CNT_W-1:0]  CNT_MIN         = 2'd0;
  localparam logic [CNT_W-1:0]  CNT_WEAK_TAKEN  = 2'd2;
  localparam logic [CNT_W-1:0]  CNT_WEAK_NTAKEN = 2'd1;
  localparam logic [ADDR_W-1:0] INSTR_BYTES     = 32'd4;

  // One branch item as it travels down the row of cells, with the result
  // gathered so far.
  typedef struct packed {
    logic              vld;
    logic              br;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tgt;
    logic              taken;
    logic              done;   // hit found or entry allocated upstream
    logic              hit;
    logic              pred;
    logic              redir;
    logic [ADDR_W-1:0] npc;
  } lhbp_item_t;

endpackage

>>> hdl/local_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Two-level local branch predictor with a branch target buffer, built as a
// row of entry cells that each branch item walks through in order.
// ----------------------------------------------------------------------------
// Path from input accept to result valid: one stage register per entry
//   cell plus the output register.
// Throughput: one item per cycle unless a held result stalls the row; items
//   walk the cell row in turn, so every entry sees them in arrival order.
// Reset (rst_n low, synchronous): clear all entry valid bits, histories,
//   pattern counters and the valid flags of every stage; tags and targets
//   hold whatever they had until an entry is allocated.
module local_history_branch_predictor #(
  parameter int TABLE_ENTRIES = lhbp_pkg::LHBP_TABLE_ENTRIES,
  parameter int HISTORY_BITS  = lhbp_pkg::LHBP_HISTORY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] br_pc, [63:32] target_addr, [64] outcome_taken, rest zero
  input  logic [lhbp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] is_branch
  input  logic                            in_tuser,
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] table_hit, [1] predicted_taken, [2] redirect, [34:3] redirect_pc
  output logic [lhbp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lhbp_pkg::*;

  lhbp_item_t chain [TABLE_ENTRIES+1];
  lhbp_item_t head;
  lhbp_item_t last;
  logic       adv;

  logic              out_vld_r;
  logic              res_hit;
  logic              res_pred;
  logic              res_redir;
  logic [ADDR_W-1:0] res_npc;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Advance the whole row whenever the tail can move: the last stage is
  // empty, the output register is empty, or the result is being taken.
  assign last      = chain[TABLE_ENTRIES];
  assign adv       = !last.vld || !out_vld_r || out_tready;
  assign in_tready = adv;

  // Unpack the input item into the head of the chain; result fields start
  // cleared so a non-branch item falls out as all zero.
  always_comb begin
    head       = '0;
    head.vld   = in_tvalid;
    head.br    = in_tuser;
    head.addr  = in_tdata[31:0];
    head.tgt   = in_tdata[63:32];
    head.taken = in_tdata[64];
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lhbp_cell #(
      .HISTORY_BITS(HISTORY_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  // A branch that found neither its entry nor a free one: table full, no
  // state change, redirect only if taken.
  always_comb begin
    res_hit   = last.hit;
    res_pred  = last.pred;
    res_redir = last.redir;
    res_npc   = last.npc;
    if (last.br && !last.done) begin
      res_hit   = 1'b0;
      res_pred  = 1'b0;
      res_redir = last.taken;
      res_npc   = last.taken ? last.tgt : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && last.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last.vld) begin
      out_data_r <= {5'd0, res_npc, res_redir, res_pred, res_hit};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/lhbp_cell.sv
// ----------------------------------------------------------------------------
// lhbp_cell
// One target buffer entry with its local history and pattern counters. Match
// or allocate for the passing item, then hand the item to the next cell.
// ----------------------------------------------------------------------------
module lhbp_cell #(
  parameter int HISTORY_BITS = lhbp_pkg::LHBP_HISTORY_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  lhbp_pkg::lhbp_item_t item_i,
  output lhbp_pkg::lhbp_item_t item_o
);
  import lhbp_pkg::*;

  localparam int HIST_DEPTH = 2 ** HISTORY_BITS;

  logic                    ent_vld_r;
  logic [ADDR_W-1:0]       tag_r;
  logic [ADDR_W-1:0]       tgt_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [CNT_W-1:0]        cnt_r [HIST_DEPTH];
  lhbp_item_t              item_r;
  lhbp_item_t              item_nxt;

  logic              act;
  logic              hit_here;
  logic              alloc_here;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_upd;
  logic [HISTORY_BITS-1:0] hist_nxt;

  assign act        = item_i.vld && item_i.br && !item_i.done;
  assign hit_here   = act && ent_vld_r && (tag_r == item_i.addr);
  assign alloc_here = act && !ent_vld_r;
  assign cnt_cur    = cnt_r[hist_r];
  assign hist_nxt   = HISTORY_BITS'({hist_r, item_i.taken});

  always_comb begin
    cnt_upd = cnt_cur;
    if (item_i.taken) begin
      if (cnt_cur != CNT_MAX) cnt_upd = cnt_cur + 2'd1;
    end else begin
      if (cnt_cur != CNT_MIN) cnt_upd = cnt_cur - 2'd1;
    end
  end

  always_comb begin
    item_nxt = item_i;
    if (hit_here) begin
      item_nxt.done = 1'b1;
      item_nxt.hit  = 1'b1;
      item_nxt.pred = cnt_cur[1];
      if (item_i.taken && !cnt_cur[1]) begin
        item_nxt.redir = 1'b1;
        item_nxt.npc   = tgt_r;
      end else if (!item_i.taken && cnt_cur[1]) begin
        item_nxt.redir = 1'b1;
        item_nxt.npc   = tag_r + INSTR_BYTES;
      end
    end else if (alloc_here) begin
      item_nxt.done = 1'b1;
      if (item_i.taken) begin
        item_nxt.redir = 1'b1;
        item_nxt.npc   = item_i.tgt;
      end
    end
  end

  // Entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      hist_r    <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        cnt_r[k] <= CNT_MIN;
      end
    end else if (adv) begin
      if (hit_here) begin
        cnt_r[hist_r] <= cnt_upd;
        hist_r        <= hist_nxt;
      end else if (alloc_here) begin
        ent_vld_r <= 1'b1;
        cnt_r[0]  <= item_i.taken ? CNT_WEAK_TAKEN : CNT_WEAK_NTAKEN;
        hist_r    <= HISTORY_BITS'(item_i.taken);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && alloc_here) begin
      tag_r <= item_i.addr;
      tgt_r <= item_i.tgt;
    end
  end

  // Stage register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

>>> tb/sv/tb_local_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// tb_local_history_branch_predictor
// Self-checking bench for the local history branch predictor. It runs a
// short directed table and then a long run of loop-like branch streams
// through the block, with random gaps and stalls on both stream sides. Every
// result is checked field by field, against a typed row or else a behavioral
// predictor with its own target buffer, local histories and pattern counters.
// ----------------------------------------------------------------------------
module tb_local_history_branch_predictor;
  timeunit 1ns;
  timeprecision 1ps;

  import lhbp_pkg::*;

  localparam int ENTRIES     = LHBP_TABLE_ENTRIES;
  localparam int HIST_W      = LHBP_HISTORY_BITS;
  localparam int LATENCY     = ENTRIES + 1;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOT_BRANCHES = 40;
  localparam int DIR_ROWS     = 17;

  // One branch item and one result, in field terms.
  typedef struct packed {
    logic              is_branch;
    logic [ADDR_W-1:0] br_pc;
    logic [ADDR_W-1:0] target_addr;
    logic              outcome_taken;
  } branch_item_t;

  typedef struct packed {
    logic              table_hit;
    logic              predicted_taken;
    logic              redirect;
    logic [ADDR_W-1:0] redirect_pc;
  } branch_result_t;

  // Directed row: when has_want is set the typed result is expected as is,
  // otherwise the predictor supplies it.
  typedef struct packed {
    logic           has_want;
    branch_item_t   stim;
    branch_result_t want;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  local_history_branch_predictor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predictor state: target buffer, per-entry local history, pattern counters.
  logic              btb_valid  [ENTRIES];
  logic [ADDR_W-1:0] btb_tag    [ENTRIES];
  logic [ADDR_W-1:0] btb_target [ENTRIES];
  logic [HIST_W-1:0] btb_hist   [ENTRIES];
  logic [CNT_W-1:0]  pht        [ENTRIES << HIST_W];
  int                btb_fill;

  branch_result_t expected_results[$];
  int fail_count;
  int item_count, branch_count, hit_count, redirect_count, full_miss_count;
  int idle_cycles;

  // Result currently on the output bus, and the one it is checked against.
  branch_result_t seen, want;

  // Directed table: non-branches at the field extremes, first misses taken
  // and not taken, a not-taken hit whose fall-through wraps past the top of
  // the address space, a taken hit redirected to the stored target (not the
  // one on the bus), counters saturating up and down, and a non-branch that
  // matches a live tag and must leave the state alone.
  directed_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, '{1'b0, 1'b0, 1'b0, 32'h0}},
    '{1'b1, '{1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0}, '{1'b0, 1'b0, 1'b0, 32'h0}},
    '{1'b1, '{1'b1, 32'hFFFF_FFFC, 32'h0000_0010, 1'b1},
            '{1'b0, 1'b0, 1'b1, 32'h0000_0010}},
    '{1'b1, '{1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, '{1'b0, 1'b0, 1'b0, 32'h0}},
    '{1'b0, '{1'b1, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0}, '0},
    '{1'b0, '{1'b1, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0}, '0},
    '{1'b0, '{1'b1, 32'hFFFF_FFFC, 32'hAAAA_AAAA, 1'b0}, '0},
    '{1'b0, '{1'b1, 32'h0000_0000, 32'h1234_5678, 1'b1}, '0},
    '{1'b1, '{1'b0, 32'hFFFF_FFFC, 32'h5555_5555, 1'b1}, '{1'b0, 1'b0, 1'b0, 32'h0}},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b1}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b0}, '0},
    '{1'b0, '{1'b1, 32'h0040_0000, 32'h0040_0100, 1'b0}, '0}
  };

  // Loop-like branches for the random part: each repeats its own outcome
  // pattern with a period of one to four, so local histories get trained.
  logic [ADDR_W-1:0] hot_addr    [HOT_BRANCHES];
  logic [ADDR_W-1:0] hot_tgt     [HOT_BRANCHES];
  logic [3:0]        hot_pattern [HOT_BRANCHES];
  int                hot_period  [HOT_BRANCHES];
  int                hot_step    [HOT_BRANCHES];

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predict one resolved branch and advance the predictor state.
  function automatic branch_result_t predict_branch(branch_item_t it);
    branch_result_t    r;
    bit                found;
    int                idx;
    int                slot;
    logic [HIST_W-1:0] h;
    logic [CNT_W-1:0]  c;
    r     = '0;
    found = 1'b0;
    idx   = 0;
    item_count++;
    if (!it.is_branch) return r;
    branch_count++;
    // Lowest valid matching entry wins.
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && btb_valid[i] && btb_tag[i] == it.br_pc) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      hit_count++;
      h    = btb_hist[idx];
      slot = (idx << HIST_W) | h;
      c    = pht[slot];
      r.table_hit       = 1'b1;
      r.predicted_taken = (c >= CNT_WEAK_TAKEN);
      if (it.outcome_taken) begin
        if (c != CNT_MAX) c = c + 1'b1;
        if (!r.predicted_taken) begin
          r.redirect    = 1'b1;
          r.redirect_pc = btb_target[idx];
        end
      end else begin
        if (c != CNT_MIN) c = c - 1'b1;
        if (r.predicted_taken) begin
          r.redirect    = 1'b1;
          r.redirect_pc = btb_tag[idx] + INSTR_BYTES;
        end
      end
      pht[slot]     = c;
      btb_hist[idx] = HIST_W'((h << 1) | it.outcome_taken);
    end else begin
      if (btb_fill < ENTRIES) begin
        btb_valid[btb_fill]  = 1'b1;
        btb_tag[btb_fill]    = it.br_pc;
        btb_target[btb_fill] = it.target_addr;
        pht[btb_fill << HIST_W] = it.outcome_taken ? CNT_WEAK_TAKEN : CNT_WEAK_NTAKEN;
        btb_hist[btb_fill]   = HIST_W'(it.outcome_taken);
        btb_fill++;
      end else begin
        full_miss_count++;
      end
      if (it.outcome_taken) begin
        r.redirect    = 1'b1;
        r.redirect_pc = it.target_addr;
      end
    end
    if (r.redirect) redirect_count++;
    return r;
  endfunction

  // Present one item after a random gap and hold it until accepted. Valid
  // is only lowered when a gap follows, so it never toggles within a step.
  task automatic send_branch(branch_item_t it, output bit accepted);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 60)      gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else             gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, it.outcome_taken, it.target_addr, it.br_pc};
    in_tuser  <= it.is_branch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accepted = 1'b1;
  endtask

  // Result side back-pressure: runs of ready, short stalls, now and then a
  // long one.
  initial begin
    int r;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (r < 93) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.table_hit       = out_tdata[0];
      seen.predicted_taken = out_tdata[1];
      seen.redirect        = out_tdata[2];
      seen.redirect_pc     = out_tdata[34:3];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, seen);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen.table_hit !== want.table_hit) begin
          $display("%0t: table_hit expected %b got %b", $time,
                   want.table_hit, seen.table_hit);
          fail_count++;
        end
        if (seen.predicted_taken !== want.predicted_taken) begin
          $display("%0t: predicted_taken expected %b got %b", $time,
                   want.predicted_taken, seen.predicted_taken);
          fail_count++;
        end
        if (seen.redirect !== want.redirect) begin
          $display("%0t: redirect expected %b got %b", $time,
                   want.redirect, seen.redirect);
          fail_count++;
        end
        if (seen.redirect_pc !== want.redirect_pc) begin
          $display("%0t: redirect_pc expected %h got %h", $time,
                   want.redirect_pc, seen.redirect_pc);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves while work is pending.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (!in_tvalid && expected_results.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("local_history_branch_predictor test failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random streams, drain, verdict.
  initial begin
    branch_item_t   it;
    branch_result_t pred;
    bit             acc;
    int             r;
    int             k;
    fail_count      = 0;
    item_count      = 0;
    branch_count    = 0;
    hit_count       = 0;
    redirect_count  = 0;
    full_miss_count = 0;
    idle_cycles     = 0;
    btb_fill        = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      btb_valid[i]  = 1'b0;
      btb_tag[i]    = '0;
      btb_target[i] = '0;
      btb_hist[i]   = '0;
    end
    for (int i = 0; i < (ENTRIES << HIST_W); i++) pht[i] = '0;
    for (int i = 0; i < HOT_BRANCHES; i++) begin
      hot_addr[i]    = $urandom() & 32'hFFFF_FFFC;
      hot_tgt[i]     = $urandom() & 32'hFFFF_FFFC;
      hot_pattern[i] = 4'($urandom());
      hot_period[i]  = $urandom_range(1, 4);
      hot_step[i]    = 0;
    end

    // Hold reset with every input at a known value.
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_branch(dir_rows[n].stim, acc);
      pred = predict_branch(dir_rows[n].stim);
      expected_results.push_back(dir_rows[n].has_want ? dir_rows[n].want : pred);
    end

    // Random part: mostly hot loop branches, some fresh addresses that fill
    // the buffer and then miss with it full, a few non-branch items.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        it.is_branch     = 1'b0;
        it.br_pc         = $urandom();
        it.target_addr   = $urandom();
        it.outcome_taken = 1'($urandom_range(0, 1));
      end else if (r < 17) begin
        it.is_branch     = 1'b1;
        it.br_pc         = $urandom();
        it.target_addr   = $urandom();
        it.outcome_taken = 1'($urandom_range(0, 1));
      end else begin
        k = $urandom_range(0, HOT_BRANCHES - 1);
        it.is_branch     = 1'b1;
        it.br_pc         = hot_addr[k];
        it.target_addr   = hot_tgt[k];
        it.outcome_taken = hot_pattern[k][hot_step[k] % hot_period[k]];
        // Flip an outcome now and then to break the pattern.
        if ($urandom_range(0, 99) < 8) it.outcome_taken = ~it.outcome_taken;
        hot_step[k]++;
      end
      send_branch(it, acc);
      expected_results.push_back(predict_branch(it));
    end
    in_tvalid <= 1'b0;

    // Drain, then give the pipe time to show any stray result.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Ran %0d items, %0d branches: %0d hits, %0d redirects,", item_count,
             branch_count, hit_count, redirect_count);
    $display("%0d buffer entries filled, %0d misses with the buffer full.", btb_fill,
             full_miss_count);
    if (fail_count == 0) begin
      $display("local_history_branch_predictor test passed");
    end else begin
      $display("local_history_branch_predictor test failed");
    end
    $finish;
  end

endmodule
